// ===== rtl/pds16_pkg.sv =====
// ---------------------------------------------------------------------------
// pds16_pkg
// Shared types and constants for the marker-framed packet deframer with a
// 16-bit additive checksum.
// ---------------------------------------------------------------------------
package pds16_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned KIND_W        = 3;
   localparam int unsigned IDX_W         = 6;
   localparam int unsigned SUM_W         = 16;
   localparam int unsigned CSR_ADDR_W    = 1;
   localparam int unsigned MAX_PAYLOAD_D = 64;

   localparam logic [SUM_W-1:0]  SUM_SEED        = 16'h0055;
   localparam logic [BYTE_W-1:0] START_MARKER_RV = 8'h02;
   localparam logic [BYTE_W-1:0] END_MARKER_RV   = 8'h03;

   // configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_START_MARKER = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_END_MARKER   = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_DATA    = 3'd0,
      KIND_LONG    = 3'd1,
      KIND_CSUM_LO = 3'd2,
      KIND_CSUM_HI = 3'd3,
      KIND_BAD_END = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_DATA = 3'd2,
      PH_CSLO = 3'd3,
      PH_CSHI = 3'd4,
      PH_END  = 3'd5,
      PH_EMIT = 3'd6
   } phase_type;

endpackage

// ===== rtl/pds16_if.sv =====
// ---------------------------------------------------------------------------
// pds16 channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ---------------------------------------------------------------------------
interface pds16_req_if;
   logic                             valid;
   logic                             ready;
   logic [pds16_pkg::BYTE_W-1:0]     rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pds16_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pds16_pkg::KIND_W-1:0]     kind;
   logic [pds16_pkg::BYTE_W-1:0]     payload_byte;
   logic [pds16_pkg::IDX_W-1:0]      byte_index;
   logic [pds16_pkg::BYTE_W-1:0]     packet_length;
   logic                             last;
   modport source (output valid, output kind, output payload_byte, output byte_index,
                   output packet_length, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input byte_index,
                   input packet_length, input last, output ready);
endinterface

interface pds16_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pds16_pkg::CSR_ADDR_W-1:0] addr;
   logic [pds16_pkg::BYTE_W-1:0]     data;
   modport source (output valid, output addr, output data, input ready);
   modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/packet_deframer_sum16.sv =====
// ---------------------------------------------------------------------------
// packet_deframer_sum16
// Marker-framed packet deframer: hunts a start marker, takes a length and
// payload into a buffer memory, checks a 16-bit additive checksum and the
// end marker, then streams the payload out or reports one error status.
// ---------------------------------------------------------------------------
//
//  channel   | dir | payload                                         | transfer
//  ----------+-----+-------------------------------------------------+---------------
//  req_chan  | in  | rx_byte                                         | valid & ready
//  rsp_chan  | out | kind, payload_byte, byte_index, packet_length,  | valid & ready
//            |     | last                                            |
//  csr_chan  | in  | addr (0 start marker, 1 end marker), data       | valid & ready
//
//  Cycles: one received byte per cycle while framing and the output register
//  is free; an error result leaves through the output register in the same
//  transfer slot. A good packet is read back from the single read port of
//  the buffer one entry per cycle while results are taken; no byte is taken
//  until the whole payload has been read out.
//  Reset: synchronous, clears phase, counters and output valid, sets the markers
//  to 2 and 3; the buffer and the output payload fields are not cleared.
//  Stalls: a held result stops intake and payload read-out until taken.
//
module packet_deframer_sum16 #(
   parameter int unsigned MAX_PAYLOAD = pds16_pkg::MAX_PAYLOAD_D
) (
   input  logic              clock,
   input  logic              reset,
   pds16_req_if.sink         req_chan,
   pds16_rsp_if.source       rsp_chan,
   pds16_csr_if.sink         csr_chan
);

   localparam int unsigned BW = pds16_pkg::BYTE_W;
   localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [BW-1:0] MAX_LEN = BW'(MAX_PAYLOAD);

   // configuration
   logic [BW-1:0] start_marker_ff;
   logic [BW-1:0] end_marker_ff;

   // framing state
   pds16_pkg::phase_type phase_ff, phase_in;
   logic [BW-1:0]                  frame_length_ff, frame_length_in;
   logic [BW-1:0]                  byte_count_ff, byte_count_in;
   logic [pds16_pkg::SUM_W-1:0]    running_sum_ff, running_sum_in;

   // payload buffer and read-out
   logic [BW-1:0] store_mem_ff [MAX_PAYLOAD];
   logic [BW-1:0] rd_data_ff;
   logic [BW-1:0] emit_idx_ff, emit_idx_in;
   logic [BW-1:0] pend_idx_ff, pend_idx_in;
   logic          pend_ff, pend_in;
   logic          wr_en;
   logic          rd_en;
   logic          load;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   pds16_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   logic [BW-1:0]         rsp_data_ff, rsp_data_in;
   logic [pds16_pkg::IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [BW-1:0]         rsp_len_ff, rsp_len_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic          out_free;
   logic          req_fire;
   logic [BW-1:0] b;
   logic [BW-1:0] count_inc;
   logic          emit_done;

   assign b         = req_chan.rx_byte;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (phase_ff != pds16_pkg::PH_EMIT) && out_free;
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign count_inc = byte_count_ff + BW'(1);
   assign csr_chan.ready = 1'b1;

   // buffer read-out: issue a read when the held word is gone or leaving
   assign load      = pend_ff && out_free;
   assign rd_en     = (phase_ff == pds16_pkg::PH_EMIT) && (emit_idx_ff != frame_length_ff)
                      && (!pend_ff || load);
   assign emit_done = (emit_idx_ff == frame_length_ff) && (!pend_ff || load);
   assign wr_en     = req_fire && (phase_ff == pds16_pkg::PH_DATA);

   // -------------------------------------------------------------------
   // next phase
   // -------------------------------------------------------------------
   always_comb begin
      phase_in = phase_ff;
      if (req_fire) begin
         unique case (phase_ff)
            pds16_pkg::PH_LEN: begin
               if (b > MAX_LEN) begin
                  phase_in = (b == start_marker_ff) ? pds16_pkg::PH_LEN : pds16_pkg::PH_HUNT;
               end else if (b == '0) begin
                  phase_in = pds16_pkg::PH_CSLO;
               end else begin
                  phase_in = pds16_pkg::PH_DATA;
               end
            end
            pds16_pkg::PH_DATA: begin
               if (count_inc >= frame_length_ff) phase_in = pds16_pkg::PH_CSLO;
            end
            pds16_pkg::PH_CSLO: begin
               if (running_sum_ff[7:0] != b) begin
                  phase_in = (b == start_marker_ff) ? pds16_pkg::PH_LEN : pds16_pkg::PH_HUNT;
               end else begin
                  phase_in = pds16_pkg::PH_CSHI;
               end
            end
            pds16_pkg::PH_CSHI: begin
               if (running_sum_ff[15:8] != b) begin
                  phase_in = (b == start_marker_ff) ? pds16_pkg::PH_LEN : pds16_pkg::PH_HUNT;
               end else begin
                  phase_in = pds16_pkg::PH_END;
               end
            end
            pds16_pkg::PH_END: begin
               if (b != end_marker_ff) begin
                  phase_in = (b == start_marker_ff) ? pds16_pkg::PH_LEN : pds16_pkg::PH_HUNT;
               end else if (frame_length_ff == '0) begin
                  phase_in = pds16_pkg::PH_HUNT;
               end else begin
                  phase_in = pds16_pkg::PH_EMIT;
               end
            end
            default: begin
               phase_in = (b == start_marker_ff) ? pds16_pkg::PH_LEN : pds16_pkg::PH_HUNT;
            end
         endcase
      end else if (phase_ff == pds16_pkg::PH_EMIT && emit_done) begin
         phase_in = pds16_pkg::PH_HUNT;
      end
   end

   // -------------------------------------------------------------------
   // datapath and result register
   // -------------------------------------------------------------------
   always_comb begin
      frame_length_in = frame_length_ff;
      byte_count_in   = byte_count_ff;
      running_sum_in  = running_sum_ff;
      emit_idx_in     = emit_idx_ff;
      pend_idx_in     = pend_idx_ff;
      pend_in         = pend_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_idx_in      = rsp_idx_ff;
      rsp_len_in      = rsp_len_ff;
      rsp_last_in     = rsp_last_ff;

      if (req_fire) begin
         // errors share one status form; kind picked per phase below
         rsp_data_in = '0;
         rsp_idx_in  = '0;
         rsp_len_in  = frame_length_ff;
         rsp_last_in = 1'b1;
         unique case (phase_ff)
            pds16_pkg::PH_LEN: begin
               if (b > MAX_LEN) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pds16_pkg::KIND_LONG;
                  rsp_len_in   = b;
               end else begin
                  frame_length_in = b;
                  byte_count_in   = '0;
                  running_sum_in  = pds16_pkg::SUM_SEED + pds16_pkg::SUM_W'(b);
               end
            end
            pds16_pkg::PH_DATA: begin
               running_sum_in = running_sum_ff + pds16_pkg::SUM_W'(b);
               byte_count_in  = count_inc;
            end
            pds16_pkg::PH_CSLO: begin
               if (running_sum_ff[7:0] != b) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pds16_pkg::KIND_CSUM_LO;
               end
            end
            pds16_pkg::PH_CSHI: begin
               if (running_sum_ff[15:8] != b) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pds16_pkg::KIND_CSUM_HI;
               end
            end
            pds16_pkg::PH_END: begin
               if (b != end_marker_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = pds16_pkg::KIND_BAD_END;
               end else begin
                  // rewind the read-out pointer for the payload stream
                  emit_idx_in = '0;
                  pend_in     = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end

      // move the buffered word into the output register
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pds16_pkg::KIND_DATA;
         rsp_data_in  = rd_data_ff;
         rsp_idx_in   = pend_idx_ff[pds16_pkg::IDX_W-1:0];
         rsp_len_in   = frame_length_ff;
         rsp_last_in  = (pend_idx_ff + BW'(1)) == frame_length_ff;
         pend_in      = 1'b0;
      end
      if (rd_en) begin
         pend_idx_in = emit_idx_ff;
         emit_idx_in = emit_idx_ff + BW'(1);
         pend_in     = 1'b1;
      end
   end

   // -------------------------------------------------------------------
   // registers
   // -------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= pds16_pkg::START_MARKER_RV;
         end_marker_ff   <= pds16_pkg::END_MARKER_RV;
         phase_ff        <= pds16_pkg::PH_HUNT;
         frame_length_ff <= '0;
         byte_count_ff   <= '0;
         running_sum_ff  <= '0;
         emit_idx_ff     <= '0;
         pend_ff         <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            unique case (csr_chan.addr)
               pds16_pkg::CSR_START_MARKER: start_marker_ff <= csr_chan.data;
               pds16_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_chan.data;
               default: begin
               end
            endcase
         end
         phase_ff        <= phase_in;
         frame_length_ff <= frame_length_in;
         byte_count_ff   <= byte_count_in;
         running_sum_ff  <= running_sum_in;
         emit_idx_ff     <= emit_idx_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload fields of the output register and the buffered index; no reset needed
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
      pend_idx_ff <= pend_idx_in;
   end

   // payload buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem_ff[byte_count_ff[AW-1:0]] <= b;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem_ff[emit_idx_ff[AW-1:0]];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.payload_byte  = rsp_data_ff;
   assign rsp_chan.byte_index    = rsp_idx_ff;
   assign rsp_chan.packet_length = rsp_len_ff;
   assign rsp_chan.last          = rsp_last_ff;

`ifndef ASSERT_OFF
   // a buffered read word exists only during payload read-out
   a_pend_in_emit: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (phase_ff == pds16_pkg::PH_EMIT))
      else $error("buffered read word outside read-out");

   // the read pointer never passes the frame length
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pds16_pkg::PH_EMIT) |-> (emit_idx_ff <= frame_length_ff))
      else $error("read-out pointer beyond frame length");

   // payload writes stay inside the current frame
   a_data_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pds16_pkg::PH_DATA) |-> (byte_count_ff < frame_length_ff))
      else $error("payload write beyond frame length");

   // loading the final payload byte ends read-out
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_last_in) |=> (phase_ff != pds16_pkg::PH_EMIT))
      else $error("read-out continues after final byte");

   // an output word is never overwritten while it waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> (!load && !req_fire))
      else $error("output register overwritten while held");
`endif

endmodule
